// File: sv/b58enc_pkg.sv
// ----------------------------------------------------------------------------
// b58enc_pkg
// Shared sizes, constants, sequencer states and the alphabet lookup for the
// Base58 encoder.
// ----------------------------------------------------------------------------
package b58enc_pkg;

  localparam int MAX_BYTES  = 32;
  localparam int MAX_DIGITS = 44;

  localparam int BIDX_W = $clog2(MAX_BYTES);
  localparam int BCNT_W = $clog2(MAX_BYTES + 1);
  localparam int DIDX_W = $clog2(MAX_DIGITS);
  localparam int DCNT_W = $clog2(MAX_DIGITS + 1);
  localparam int SUM_W  = $clog2(MAX_BYTES + MAX_DIGITS + 1);

  localparam int BYTE_W  = 8;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [DIGIT_W-1:0] BASE = DIGIT_W'(58);

  // partial dividend {remainder, byte} stays below 58 * 256
  localparam int CUR_W       = DIGIT_W + BYTE_W;
  // reciprocal of 58 scaled by 2**20, exact over the partial dividend range
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(18079);
  localparam int PROD_W      = CUR_W + RECIP_W;

  localparam logic [CHAR_W-1:0] CHAR_ONE = CHAR_W'(8'h31);

  localparam logic [8*58-1:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DRD,
    S_DMUL,
    S_DWB,
    S_PEND,
    S_ESET,
    S_EZ,
    S_ERD,
    S_EOUT,
    S_OVF
  } state_t;

  function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = '0;
    if (d < BASE) begin
      c = ALPHABET[(57 - int'(d)) * 8 +: CHAR_W];
    end
    return c;
  endfunction

endpackage

// File: sv/b58enc_if.sv
// ----------------------------------------------------------------------------
// b58enc_if
// Valid/ready channels of the Base58 encoder: message bytes in, text out.
// ----------------------------------------------------------------------------
interface b58enc_byte_if import b58enc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b58enc_char_if import b58enc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              last_char;
  logic              overflow;

  modport source (output valid, output text_char, output last_char, output overflow,
                  input ready);
  modport sink   (input valid, input text_char, input last_char, input overflow,
                  output ready);
endinterface

// File: sv/b58enc_div58.sv
// ----------------------------------------------------------------------------
// b58enc_div58
// Shared divide-by-58 step: registered reciprocal product, then quotient and
// remainder by shift-add back-multiply.
// ----------------------------------------------------------------------------
module b58enc_div58 import b58enc_pkg::*; (
  input  logic               clk,
  input  logic               load,
  input  logic [CUR_W-1:0]   cur,
  output logic [BYTE_W-1:0]  quot,
  output logic [DIGIT_W-1:0] rem
);

  logic [CUR_W-1:0]  cur_q;
  logic [PROD_W-1:0] prod;
  logic [CUR_W-1:0]  back;
  logic [CUR_W-1:0]  diff;

  always_ff @(posedge clk) begin
    if (load) begin
      cur_q <= cur;
      prod  <= PROD_W'(cur) * PROD_W'(RECIP);
    end
  end

  assign quot = prod[RECIP_SHIFT +: BYTE_W];

  // quot * 58 as 32 + 16 + 8 + 2
  assign back = CUR_W'({quot, 5'b0}) + CUR_W'({quot, 4'b0})
              + CUR_W'({quot, 3'b0}) + CUR_W'({quot, 1'b0});
  assign diff = cur_q - back;
  assign rem  = diff[DIGIT_W-1:0];

endmodule

// File: sv/base58_encoder.sv
// ----------------------------------------------------------------------------
// base58_encoder
// Base58 text encoder, Bitcoin alphabet, one shared divide-by-58 unit.
// ----------------------------------------------------------------------------
// data_in carries message bytes, most significant first; last_byte closes a
// message. A byte that is not last is taken with ready staying high. On the
// last byte ready drops while the value is divided by 58 pass after pass in
// the single divider; each pass reads, divides and writes back every byte
// still in use (S_DRD, S_DMUL, S_DWB) and then stores a digit (S_PEND).
// text_out then gives one beat per character: each leading '1' directly,
// each digit after a read of the digit buffer (S_ERD, then S_EOUT).
// Too long a message gives a single beat with overflow set and char 0.
// The result sits in an output register, so a new message is taken while
// the last character still waits. When the receiver stalls, the sequencer
// holds until the output register is free. Synchronous reset clears the
// sequencer and message counters; no clearing pass of the buffers is run.
// ----------------------------------------------------------------------------
module base58_encoder import b58enc_pkg::*; (
  input logic             clk,
  input logic             rst,
  b58enc_byte_if.sink     data_in,
  b58enc_char_if.source   text_out
);

  state_t state, state_next;

  logic [BCNT_W-1:0]  byte_count;
  logic [BCNT_W-1:0]  lzc;
  logic               seen_nz;
  logic               too_long;
  logic [BCNT_W-1:0]  idx;
  logic [BCNT_W-1:0]  new_start;
  logic               pass_nz;
  logic [DIGIT_W-1:0] rem_acc;
  logic [DCNT_W-1:0]  nd;
  logic [DCNT_W-1:0]  zleft;
  logic [DCNT_W-1:0]  dleft;
  logic [DIDX_W-1:0]  dig_idx;

  logic [BYTE_W-1:0]  byte_mem [MAX_BYTES];
  logic [BYTE_W-1:0]  rd_byte;
  logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] dig_rd;

  logic               o_valid;
  logic [CHAR_W-1:0]  o_char;
  logic               o_last;
  logic               o_ovf;

  logic               accept;
  logic               out_free;
  logic               out_load;
  logic [CHAR_W-1:0]  ld_char;
  logic               ld_last;
  logic               ld_ovf;
  logic               byte_we;
  logic [BIDX_W-1:0]  byte_waddr;
  logic [BYTE_W-1:0]  byte_wdata;
  logic               dig_we;
  logic               div_load;
  logic [BYTE_W-1:0]  div_quot;
  logic [DIGIT_W-1:0] div_rem;
  logic               room;
  logic               to_ovf;
  logic [SUM_W-1:0]   zc_calc;
  logic [SUM_W-1:0]   tot_calc;
  logic [DCNT_W:0]    nd_inc;

  b58enc_div58 u_div (
    .clk  (clk),
    .load (div_load),
    .cur  ({rem_acc, rd_byte}),
    .quot (div_quot),
    .rem  (div_rem)
  );

  assign accept   = data_in.valid && data_in.ready;
  assign out_free = !o_valid || text_out.ready;
  assign room     = byte_count < BCNT_W'(MAX_BYTES);
  assign to_ovf   = too_long || !room;
  assign nd_inc   = {1'b0, nd} + 1'b1;

  // leading ones capped, then total capped
  always_comb begin
    zc_calc = SUM_W'(lzc);
    if (zc_calc > SUM_W'(MAX_DIGITS)) begin
      zc_calc = SUM_W'(MAX_DIGITS);
    end
    tot_calc = zc_calc + SUM_W'(nd);
    if (tot_calc > SUM_W'(MAX_DIGITS)) begin
      tot_calc = SUM_W'(MAX_DIGITS);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && data_in.last_byte) begin
          state_next = to_ovf ? S_OVF : S_PREP;
        end
      end
      S_PREP: state_next = (lzc == byte_count) ? S_ESET : S_DRD;
      S_DRD:  state_next = S_DMUL;
      S_DMUL: state_next = S_DWB;
      S_DWB:  state_next = (idx + 1'b1 == byte_count) ? S_PEND : S_DRD;
      S_PEND: begin
        if (new_start < byte_count && nd_inc < (DCNT_W + 1)'(MAX_DIGITS)) begin
          state_next = S_DRD;
        end else begin
          state_next = S_ESET;
        end
      end
      S_ESET: state_next = (zc_calc != '0) ? S_EZ : S_ERD;
      S_EZ: begin
        if (out_free && zleft == DCNT_W'(1)) begin
          state_next = (dleft == '0) ? S_IDLE : S_ERD;
        end
      end
      S_ERD:  state_next = S_EOUT;
      S_EOUT: begin
        if (out_free) begin
          state_next = (dleft == DCNT_W'(1)) ? S_IDLE : S_ERD;
        end
      end
      S_OVF: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    data_in.ready = (state == S_IDLE);
    div_load      = (state == S_DMUL);
    dig_we        = (state == S_PEND);
    byte_we       = 1'b0;
    byte_waddr    = byte_count[BIDX_W-1:0];
    byte_wdata    = data_in.data_byte;
    out_load      = 1'b0;
    ld_char       = '0;
    ld_last       = 1'b0;
    ld_ovf        = 1'b0;
    case (state)
      S_IDLE: byte_we = accept && room;
      S_DWB: begin
        byte_we    = 1'b1;
        byte_waddr = idx[BIDX_W-1:0];
        byte_wdata = div_quot;
      end
      S_EZ: begin
        out_load = out_free;
        ld_char  = CHAR_ONE;
        ld_last  = (zleft == DCNT_W'(1)) && (dleft == '0);
      end
      S_EOUT: begin
        out_load = out_free;
        ld_char  = b58_char(dig_rd);
        ld_last  = (dleft == DCNT_W'(1));
      end
      S_OVF: begin
        out_load = out_free;
        ld_last  = 1'b1;
        ld_ovf   = 1'b1;
      end
      default: ;
    endcase
  end

  // buffers
  always_ff @(posedge clk) begin
    if (byte_we) begin
      byte_mem[byte_waddr] <= byte_wdata;
    end
    rd_byte <= byte_mem[idx[BIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (dig_we) begin
      digit_mem[nd[DIDX_W-1:0]] <= rem_acc;
    end
    dig_rd <= digit_mem[dig_idx];
  end

  // sequencer and message state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      byte_count <= '0;
      lzc        <= '0;
      seen_nz    <= 1'b0;
      too_long   <= 1'b0;
      nd         <= '0;
      zleft      <= '0;
      dleft      <= '0;
      o_valid    <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (room) begin
              byte_count <= byte_count + 1'b1;
              if (!seen_nz) begin
                if (data_in.data_byte == '0) begin
                  lzc <= lzc + 1'b1;
                end else begin
                  seen_nz <= 1'b1;
                end
              end
            end else begin
              too_long <= 1'b1;
            end
          end
        end
        S_PREP: begin
          idx       <= lzc;
          new_start <= lzc;
          rem_acc   <= '0;
          pass_nz   <= 1'b0;
          nd        <= '0;
        end
        S_DWB: begin
          rem_acc <= div_rem;
          idx     <= idx + 1'b1;
          if (div_quot != '0) begin
            pass_nz <= 1'b1;
          end else if (!pass_nz) begin
            new_start <= idx + 1'b1;
          end
        end
        S_PEND: begin
          nd      <= nd_inc[DCNT_W-1:0];
          idx     <= new_start;
          rem_acc <= '0;
          pass_nz <= 1'b0;
        end
        S_ESET: begin
          zleft      <= zc_calc[DCNT_W-1:0];
          dleft      <= DCNT_W'(tot_calc - zc_calc);
          dig_idx    <= DIDX_W'(nd - 1'b1);
          byte_count <= '0;
          lzc        <= '0;
          seen_nz    <= 1'b0;
          too_long   <= 1'b0;
        end
        S_EZ: begin
          if (out_free) begin
            zleft <= zleft - 1'b1;
          end
        end
        S_EOUT: begin
          if (out_free) begin
            dleft   <= dleft - 1'b1;
            dig_idx <= dig_idx - 1'b1;
          end
        end
        S_OVF: begin
          if (out_free) begin
            byte_count <= '0;
            lzc        <= '0;
            seen_nz    <= 1'b0;
            too_long   <= 1'b0;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        o_valid <= 1'b1;
      end else if (text_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_char <= ld_char;
      o_last <= ld_last;
      o_ovf  <= ld_ovf;
    end
  end

  assign text_out.valid     = o_valid;
  assign text_out.text_char = o_char;
  assign text_out.last_char = o_last;
  assign text_out.overflow  = o_ovf;

  // checks
  a_ovf_beat: assert property (@(posedge clk) disable iff (rst)
    text_out.valid && text_out.overflow |-> text_out.last_char && text_out.text_char == '0)
    else $error("overflow beat not a lone terminal zero");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DWB |-> div_rem < BASE)
    else $error("divider remainder out of range");

  a_nd_cap: assert property (@(posedge clk) disable iff (rst)
    nd <= DCNT_W'(MAX_DIGITS))
    else $error("digit count beyond buffer");

  a_bcnt_cap: assert property (@(posedge clk) disable iff (rst)
    byte_count <= BCNT_W'(MAX_BYTES))
    else $error("byte count beyond buffer");

endmodule

// File: verif/b58enc_checker.sv
// ----------------------------------------------------------------------------
// b58enc_checker
// Watches both channels of the Base58 encoder. Every accepted byte updates a
// private copy of the message state; a byte marked last produces the expected
// text, which is then compared field by field with each accepted character.
// ----------------------------------------------------------------------------
module b58enc_checker import b58enc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  b58enc_byte_if      byte_ch,
  b58enc_char_if      char_ch,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  localparam string B58_SYMBOLS =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
    logic              overflow;
  } char_beat_t;

  logic [BYTE_W-1:0] msg_buf [MAX_BYTES];
  int unsigned       msg_len;
  int unsigned       zero_run;
  bit                nonzero_seen;
  bit                overlong;
  char_beat_t        text_queue [$];

  // repeated long division of the stored value by 58
  function automatic void encode_message();
    logic [BYTE_W-1:0]  work [MAX_BYTES];
    logic [DIGIT_W-1:0] digits [MAX_DIGITS];
    int unsigned        i, first, ndig, lead, total, rem, cur;
    char_beat_t         beat;
    for (i = 0; i < msg_len; i++) work[i] = msg_buf[i];
    first = 0;
    while (first < msg_len && work[first] == '0) first++;
    ndig = 0;
    while (first < msg_len && ndig < MAX_DIGITS) begin
      rem = 0;
      for (i = first; i < msg_len; i++) begin
        cur     = rem * 256 + work[i];
        work[i] = BYTE_W'(cur / 58);
        rem     = cur % 58;
      end
      digits[ndig] = DIGIT_W'(rem);
      ndig++;
      while (first < msg_len && work[first] == '0) first++;
    end
    lead  = (zero_run > MAX_DIGITS) ? MAX_DIGITS : zero_run;
    total = (lead + ndig > MAX_DIGITS) ? MAX_DIGITS : lead + ndig;
    for (i = 0; i < total; i++) begin
      if (i < lead) beat.text_char = CHAR_W'(B58_SYMBOLS[0]);
      else beat.text_char = CHAR_W'(B58_SYMBOLS[int'(digits[ndig - 1 - (i - lead)])]);
      beat.last_char = (i + 1 == total);
      beat.overflow  = 1'b0;
      text_queue.push_back(beat);
    end
  endfunction

  function automatic void take_byte(input logic [BYTE_W-1:0] b, input logic lst);
    char_beat_t beat;
    if (msg_len < MAX_BYTES) begin
      msg_buf[msg_len] = b;
      msg_len++;
      if (!nonzero_seen) begin
        if (b == '0) zero_run++;
        else nonzero_seen = 1'b1;
      end
    end else begin
      overlong = 1'b1;
    end
    if (lst) begin
      if (overlong) begin
        beat.text_char = '0;
        beat.last_char = 1'b1;
        beat.overflow  = 1'b1;
        text_queue.push_back(beat);
      end else begin
        encode_message();
      end
      msg_len      = 0;
      zero_run     = 0;
      nonzero_seen = 1'b0;
      overlong     = 1'b0;
    end
  endfunction

  function automatic void check_char();
    char_beat_t want;
    if (text_queue.size() == 0) begin
      $error("unexpected character beat: text_char %h last_char %b overflow %b",
             char_ch.text_char, char_ch.last_char, char_ch.overflow);
      fail_count++;
    end else begin
      want = text_queue.pop_front();
      if (char_ch.text_char !== want.text_char) begin
        $error("text_char: expected %h actual %h", want.text_char, char_ch.text_char);
        fail_count++;
      end
      if (char_ch.last_char !== want.last_char) begin
        $error("last_char: expected %b actual %b", want.last_char, char_ch.last_char);
        fail_count++;
      end
      if (char_ch.overflow !== want.overflow) begin
        $error("overflow: expected %b actual %b", want.overflow, char_ch.overflow);
        fail_count++;
      end
    end
  endfunction

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      msg_len      = 0;
      zero_run     = 0;
      nonzero_seen = 1'b0;
      overlong     = 1'b0;
      text_queue.delete();
      outstanding <= 0;
    end else begin
      if (char_ch.valid && char_ch.ready) check_char();
      if (byte_ch.valid && byte_ch.ready) take_byte(byte_ch.data_byte, byte_ch.last_byte);
      outstanding <= text_queue.size();
    end
  end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives messages into the Base58 encoder with random gaps and back-pressure,
// including a long receiver hold-off that fills the block, and gives the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top import b58enc_pkg::*; ();

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_FF, FILL_LEADZ} fill_t;

  logic        clk;
  logic        rst = 1'b1;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned bytes_sent;
  bit          tx_eager;
  bit          rx_hold_request;

  b58enc_byte_if data_ch ();
  b58enc_char_if text_ch ();

  base58_encoder DUT (
    .clk      (clk),
    .rst      (rst),
    .data_in  (data_ch),
    .text_out (text_ch)
  );

  b58enc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .byte_ch     (data_ch),
    .char_ch     (text_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst);
    int unsigned gap;
    gap = tx_eager ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      @(negedge clk);
      data_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    data_ch.valid     <= 1'b1;
    data_ch.data_byte <= b;
    data_ch.last_byte <= lst;
    do @(posedge clk); while (!data_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_message(input int unsigned len, input fill_t fill);
    int unsigned       i, zeros;
    logic [BYTE_W-1:0] b;
    zeros    = (fill == FILL_LEADZ) ? $urandom_range(1, len - 1) : 0;
    tx_eager = ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = '0;
        FILL_FF:   b = '1;
        default:   b = BYTE_W'($urandom);
      endcase
      if (i < zeros) b = '0;
      send_byte(b, i == len - 1);
    end
  endtask

  // receiver: random stalls, eager stretches, one long hold-off on request
  initial begin
    int unsigned stall, beats_left;
    bit          eager;
    beats_left    = 0;
    eager         = 1'b0;
    text_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (beats_left == 0) begin
        eager      = ($urandom_range(0, 3) == 0);
        beats_left = 24;
      end
      beats_left--;
      stall = eager ? 0 : $urandom_range(0, 3);
      if (rx_hold_request) begin
        stall           = 300;
        rx_hold_request = 1'b0;
      end
      if (stall != 0) begin
        @(negedge clk);
        text_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      text_ch.ready <= 1'b1;
      do @(posedge clk); while (!text_ch.valid);
    end
  end

  initial begin
    int unsigned pick, i;
    data_ch.valid     = 1'b0;
    data_ch.data_byte = '0;
    data_ch.last_byte = 1'b0;
    bytes_sent        = 0;
    tx_eager          = 1'b0;
    rx_hold_request   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single bytes at the edges of the digit range
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h39, 1'b1);
    send_byte(8'h3A, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b1);
    // leading zeros before a value, then an all-zero message
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b1);
    send_message(3, FILL_ZERO);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    // full buffer, longest text, overflow
    send_message(MAX_BYTES, FILL_FF);
    send_message(MAX_BYTES, FILL_ZERO);
    send_message(MAX_BYTES + 1, FILL_RANDOM);

    // long hold-off while short messages keep coming
    rx_hold_request = 1'b1;
    for (i = 0; i < 10; i++) send_message($urandom_range(1, 2), FILL_RANDOM);

    while (bytes_sent < 320) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) send_message($urandom_range(1, 12), FILL_RANDOM);
      else if (pick < 14) send_message($urandom_range(2, 12), FILL_LEADZ);
      else if (pick < 15) send_message($urandom_range(1, MAX_BYTES), FILL_ZERO);
      else if (pick < 18) send_message($urandom_range(13, MAX_BYTES), FILL_RANDOM);
      else if (pick < 19) send_message($urandom_range(1, MAX_BYTES), FILL_FF);
      else send_message($urandom_range(MAX_BYTES + 1, MAX_BYTES + 4), FILL_RANDOM);
    end
    @(negedge clk);
    data_ch.valid <= 1'b0;

    wait (outstanding == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
